// ===== src/miq_pkg.sv =====
// ----------------------------------------------------------------------------
// miq_pkg: shared types and constants for the middle insert queue
// Payload structs, request and status codes, storage geometry and the
// circular index helpers used by the control stage.
// ----------------------------------------------------------------------------
package miq_pkg;

    localparam int CAPACITY   = 1024;
    localparam int HALF_DEPTH = (CAPACITY + 1) / 2;
    localparam int IDX_W      = (HALF_DEPTH > 1) ? $clog2(HALF_DEPTH) : 1;
    localparam int CNT_W      = $clog2(HALF_DEPTH + 1);
    localparam int TOT_W      = CNT_W + 1;
    localparam int DATA_W     = 32;
    localparam int KIND_W     = 2;
    localparam int STAT_W     = 2;
    localparam int LEN_W      = 11;

    // Request kinds; any kind with the pop bit set is a pop
    localparam logic [KIND_W-1:0] KIND_PUSH_BACK = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_MID  = 2'd1;
    localparam int                KIND_POP_BIT   = 1;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_PUSHED = 2'd0;
    localparam logic [STAT_W-1:0] STAT_POPPED = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_FULL   = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic signed [DATA_W-1:0] value_in;
    } miq_in_t;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic signed [DATA_W-1:0] value_out;
        logic [LEN_W-1:0]         line_length;
    } miq_out_t;

    // Work plan for one transaction, built at accept time
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [LEN_W-1:0]  line_length;
        logic              pop_ok;
        logic              front_re;
        logic [IDX_W-1:0]  front_raddr;
        logic              front_we;
        logic [IDX_W-1:0]  front_waddr;
        logic              move_from_back;
        logic              back_re;
        logic [IDX_W-1:0]  back_raddr;
        logic              back_we;
        logic [IDX_W-1:0]  back_waddr;
        logic [DATA_W-1:0] val;
    } miq_plan_t;

    // idx + cnt modulo HALF_DEPTH; idx < HALF_DEPTH and cnt <= HALF_DEPTH
    function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] idx,
                                                  input logic [CNT_W-1:0] cnt);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(idx) + (CNT_W+1)'(cnt);
        if (sum >= (CNT_W+1)'(HALF_DEPTH)) begin
            sum = sum - (CNT_W+1)'(HALF_DEPTH);
        end
        return IDX_W'(sum);
    endfunction

    function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] res;
        if (idx == '0) begin
            res = IDX_W'(HALF_DEPTH - 1);
        end else begin
            res = idx - IDX_W'(1);
        end
        return res;
    endfunction

endpackage

// ===== src/miq_half_ram.sv =====
// ----------------------------------------------------------------------------
// miq_half_ram: storage for one half of the line
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module miq_half_ram (
    input  logic                       aclk,
    input  logic                       we,
    input  logic [miq_pkg::IDX_W-1:0]  waddr,
    input  logic [miq_pkg::DATA_W-1:0] wdata,
    input  logic                       re,
    input  logic [miq_pkg::IDX_W-1:0]  raddr,
    output logic [miq_pkg::DATA_W-1:0] rdata
);
    import miq_pkg::*;

    logic [DATA_W-1:0] mem [HALF_DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/miq_ctrl.sv =====
// ----------------------------------------------------------------------------
// miq_ctrl: head pointers and counts of both halves
// Decides each transaction from the request kind and the counts alone and
// updates the pointers as the transaction is accepted.
// ----------------------------------------------------------------------------
module miq_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  miq_pkg::miq_in_t    item,
    output miq_pkg::miq_plan_t  plan
);
    import miq_pkg::*;

    logic [IDX_W-1:0] front_head_reg, front_head_next;
    logic [CNT_W-1:0] front_count_reg, front_count_next;
    logic [IDX_W-1:0] back_head_reg, back_head_next;
    logic [CNT_W-1:0] back_count_reg, back_count_next;
    logic [TOT_W-1:0] total;
    logic [TOT_W-1:0] total_next;
    logic             halves_even;

    assign total       = TOT_W'(front_count_reg) + TOT_W'(back_count_reg);
    assign halves_even = (front_count_reg == back_count_reg);

    always_comb begin
        plan             = '0;
        plan.val         = item.value_in;
        front_head_next  = front_head_reg;
        front_count_next = front_count_reg;
        back_head_next   = back_head_reg;
        back_count_next  = back_count_reg;

        if (item.kind[KIND_POP_BIT]) begin
            if (front_count_reg == '0) begin
                plan.status = STAT_EMPTY;
            end else begin
                plan.status      = STAT_POPPED;
                plan.pop_ok      = 1'b1;
                plan.front_re    = 1'b1;
                plan.front_raddr = front_head_reg;
                front_head_next  = wrap_add(front_head_reg, CNT_W'(1));
                front_count_next = front_count_reg - CNT_W'(1);
                if (halves_even) begin
                    // refill the front tail from the back head
                    plan.back_re        = 1'b1;
                    plan.back_raddr     = back_head_reg;
                    plan.front_we       = 1'b1;
                    plan.front_waddr    = wrap_add(front_head_reg, front_count_reg);
                    plan.move_from_back = 1'b1;
                    back_head_next      = wrap_add(back_head_reg, CNT_W'(1));
                    back_count_next     = back_count_reg - CNT_W'(1);
                    front_count_next    = front_count_reg;
                end
            end
        end else if (total >= TOT_W'(CAPACITY)) begin
            plan.status = STAT_FULL;
        end else if (item.kind == KIND_PUSH_BACK) begin
            plan.status = STAT_PUSHED;
            if (halves_even) begin
                plan.front_we    = 1'b1;
                plan.front_waddr = wrap_add(front_head_reg, front_count_reg);
                front_count_next = front_count_reg + CNT_W'(1);
                if (back_count_reg != '0) begin
                    // append at back tail, move back head to front tail
                    plan.back_we        = 1'b1;
                    plan.back_waddr     = wrap_add(back_head_reg, back_count_reg);
                    plan.back_re        = 1'b1;
                    plan.back_raddr     = back_head_reg;
                    plan.move_from_back = 1'b1;
                    back_head_next      = wrap_add(back_head_reg, CNT_W'(1));
                end
            end else begin
                plan.back_we    = 1'b1;
                plan.back_waddr = wrap_add(back_head_reg, back_count_reg);
                back_count_next = back_count_reg + CNT_W'(1);
            end
        end else begin
            plan.status = STAT_PUSHED;
            if (halves_even) begin
                // the new value would move straight on to the front tail
                plan.front_we    = 1'b1;
                plan.front_waddr = wrap_add(front_head_reg, front_count_reg);
                front_count_next = front_count_reg + CNT_W'(1);
            end else begin
                plan.back_we    = 1'b1;
                plan.back_waddr = wrap_dec(back_head_reg);
                back_head_next  = wrap_dec(back_head_reg);
                back_count_next = back_count_reg + CNT_W'(1);
            end
        end

        total_next       = TOT_W'(front_count_next) + TOT_W'(back_count_next);
        plan.line_length = LEN_W'(total_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_head_reg  <= '0;
            front_count_reg <= '0;
            back_head_reg   <= '0;
            back_count_reg  <= '0;
        end else if (accept) begin
            front_head_reg  <= front_head_next;
            front_count_reg <= front_count_next;
            back_head_reg   <= back_head_next;
            back_count_reg  <= back_count_next;
        end
    end

endmodule

// ===== src/middle_insert_queue.sv =====
// Path: an accepted transaction is registered into stage 2 together with
//   the memory reads, then into the output register, which raises m_valid.
// Throughput: one transaction per cycle unless the output stalls, paced by
//   the registered half-line memory reads and front-half forwarding.
// Reset: synchronous, active low; clears counts, head pointers and valids.
//   Memory contents are not cleared and are used only after being written.
// ----------------------------------------------------------------------------
// middle_insert_queue: FIFO line with insertion at its middle
// The line is held as a front half and a back half in two circular memories.
// Stage 1 plans each transaction from the counts and writes the back half,
// stage 2 writes the front half and fills the output register.
// ----------------------------------------------------------------------------
module middle_insert_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  miq_pkg::miq_in_t   s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output miq_pkg::miq_out_t  m_data
);
    import miq_pkg::*;

    miq_plan_t         plan;
    miq_plan_t         s2_plan_reg;
    logic              s2_valid_reg;
    logic              fwd_hit_reg;
    logic [DATA_W-1:0] fwd_data_reg;
    logic              out_valid_reg;
    miq_out_t          out_data_reg;

    logic              accept;
    logic              advance;
    logic              s2_commit;
    logic              fwd_hit_next;
    logic [DATA_W-1:0] front_rdata;
    logic [DATA_W-1:0] back_rdata;
    logic [DATA_W-1:0] front_wdata;
    logic [DATA_W-1:0] pop_data;
    miq_out_t          result;

    // Advance stage 2 whenever the output register is free or drained
    assign advance   = !out_valid_reg || m_ready;
    assign s2_commit = s2_valid_reg && advance;
    assign s_ready   = !s2_valid_reg || advance;
    assign accept    = s_valid && s_ready;

    miq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .item    (s_data),
        .plan    (plan)
    );

    // Front half: read at accept, written when stage 2 commits
    miq_half_ram u_front_ram (
        .aclk  (aclk),
        .we    (s2_commit && s2_plan_reg.front_we),
        .waddr (s2_plan_reg.front_waddr),
        .wdata (front_wdata),
        .re    (accept),
        .raddr (plan.front_raddr),
        .rdata (front_rdata)
    );

    // Back half: the written value is the request value, so write at accept
    miq_half_ram u_back_ram (
        .aclk  (aclk),
        .we    (accept && plan.back_we),
        .waddr (plan.back_waddr),
        .wdata (plan.val),
        .re    (accept),
        .raddr (plan.back_raddr),
        .rdata (back_rdata)
    );

    // Value moving onto the front tail: back head or the pushed value
    assign front_wdata = s2_plan_reg.move_from_back ? back_rdata : s2_plan_reg.val;

    // A pop may read the front entry the previous transaction is writing now
    assign fwd_hit_next = s2_valid_reg && s2_plan_reg.front_we && plan.front_re
                          && (s2_plan_reg.front_waddr == plan.front_raddr);

    assign pop_data = fwd_hit_reg ? fwd_data_reg : front_rdata;

    always_comb begin
        result.status      = s2_plan_reg.status;
        result.value_out   = s2_plan_reg.pop_ok ? pop_data : '0;
        result.line_length = s2_plan_reg.line_length;
    end

    // Stage 2 holds while the output register is stalled
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s2_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s2_plan_reg  <= plan;
            fwd_hit_reg  <= fwd_hit_next;
            fwd_data_reg <= front_wdata;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_commit) begin
            out_data_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

// ===== src/miq_checker.sv =====
// ----------------------------------------------------------------------------
// miq_checker: port-level checks for the middle insert queue
// Watches the result channel over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module miq_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input miq_pkg::miq_in_t   s_data,
    input logic               m_valid,
    input logic               m_ready,
    input miq_pkg::miq_out_t  m_data
);
    import miq_pkg::*;

    logic unused_in;
    assign unused_in = s_valid ^ s_ready ^ (^s_data);

    // Hold a stalled result transaction
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_value_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status != STAT_POPPED) |-> (m_data.value_out == '0))
        else $error("value_out nonzero without a pop");

    a_empty_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == STAT_EMPTY) |-> (m_data.line_length == '0))
        else $error("empty pop with nonzero length");

    a_full_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == STAT_FULL)
        |-> (m_data.line_length == LEN_W'(CAPACITY)))
        else $error("full push with wrong length");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind middle_insert_queue miq_checker u_miq_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
